### sv/sound_lump_to_pcm16_resampler_top_macros.svh
// Assertion macros for the sound lump to PCM16 resampler checker.
`ifndef SOUND_LUMP_TO_PCM16_RESAMPLER_TOP_MACROS_SVH
`define SOUND_LUMP_TO_PCM16_RESAMPLER_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define SLTP_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define SLTP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Condition that must hold in the cycle after a reset cycle.
`define SLTP_ASSERT_AFTER_RESET(lbl, post, msg) \
  lbl: assert property (@(posedge clk) rst |=> (post)) else $error(msg);

`endif

### sv/sltp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the sound lump to PCM16 resampler.
package sltp_pkg;

  // Width of the sample counter; larger counts are rejected by the header check.
  localparam int          COUNT_BITS   = 24;
  localparam logic [32:0] COUNT_LIMIT  = 33'((64'd1 << COUNT_BITS) - 64'd1);

  localparam logic [15:0] OUT_RATE     = 16'd44100;
  localparam logic [15:0] HALF_RATE    = 16'd22050;
  localparam logic [15:0] QUARTER_RATE = 16'd11025;
  localparam logic [15:0] MIN_RATE     = 16'd700;
  localparam logic [15:0] HDR_VERSION  = 16'd3;
  localparam logic [7:0]  SIGN_FLIP    = 8'h80;

  localparam int          STEP_BITS    = 18;
  localparam int          INC_BITS     = 17;
  localparam logic [STEP_BITS-1:0] ONE_STEP = STEP_BITS'(32'h10000);
  localparam logic [5:0]  REPEAT_CAP   = 6'd63;

  // (rate << 16) / 44100 equals rate * 16384 / 11025. The reciprocal below is
  // ceil(2^44 / 11025); with a 30-bit shift it gives the exact quotient for
  // every 16-bit rate.
  localparam int          INC_SHIFT    = 30;
  localparam logic [30:0] INC_RECIP    = 31'd1595663134;

  localparam logic [2:0]  HDR_LAST     = 3'd7;

  localparam int          QUEUE_DEPTH    = 4;
  localparam int          QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [2:0]  ST_OK          = 3'd0;
  localparam logic [2:0]  ST_BAD_VERSION = 3'd1;
  localparam logic [2:0]  ST_RATE_LOW    = 3'd2;
  localparam logic [2:0]  ST_TOO_MANY    = 3'd3;
  localparam logic [2:0]  ST_SHORT       = 3'd4;

  typedef enum logic [1:0] {MODE_1X, MODE_2X, MODE_4X, MODE_STEP} rate_mode_t;
  typedef enum logic [1:0] {FR_HEADER, FR_BODY} front_state_t;
  typedef enum logic [1:0] {BK_EMPTY, BK_FRAMES, BK_STATUS} back_state_t;

  typedef struct packed {
    logic [7:0] lump_byte;
    logic       lump_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               is_status;
    logic [2:0]         status_code;
    logic               last_item;
  } out_item_t;

  // One queue entry: an optional sample to expand, then an optional status.
  typedef struct packed {
    logic                has_sample;
    logic [15:0]         sample_value;
    rate_mode_t          mode;
    logic [INC_BITS-1:0] step_inc;
    logic                has_status;
    logic [2:0]          code;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

### sv/sltp_front.sv
`timescale 1ns / 1ps
// Front end: parses the lump header, classifies bytes and queues commands.
module sltp_front
  import sltp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      lump_valid,
  output logic      lump_stall,
  input  in_item_t  lump,
  output logic      push,
  output cmd_t      push_cmd,
  input  q_status_t q_status
);

  front_state_t          state, state_next;
  logic [2:0]            hdr_idx;
  logic [15:0]           version_word, rate_word;
  logic [31:0]           sample_total;
  logic [COUNT_BITS-1:0] samples_taken;
  rate_mode_t            rate_mode;
  logic [INC_BITS-1:0]   step_inc;
  logic [2:0]            err_code;

  logic                  accept;
  logic [15:0]           version_hdr, rate_hdr;
  logic [31:0]           total_hdr;
  logic [2:0]            hdr_err;
  rate_mode_t            hdr_mode;
  logic                  body_sample;
  logic [COUNT_BITS-1:0] taken_after;
  logic [INC_SHIFT+INC_BITS-1:0] inc_prod;
  logic [INC_BITS-1:0]   inc_quo;

  assign lump_stall = q_status.full;
  assign accept     = lump_valid && !lump_stall;

  // Header bytes arrive little-endian.
  always_comb begin
    version_hdr = version_word;
    rate_hdr    = rate_word;
    total_hdr   = sample_total;
    case (hdr_idx)
      3'd0: version_hdr[7:0]  = lump.lump_byte;
      3'd1: version_hdr[15:8] = lump.lump_byte;
      3'd2: rate_hdr[7:0]     = lump.lump_byte;
      3'd3: rate_hdr[15:8]    = lump.lump_byte;
      3'd4: total_hdr[7:0]    = lump.lump_byte;
      3'd5: total_hdr[15:8]   = lump.lump_byte;
      3'd6: total_hdr[23:16]  = lump.lump_byte;
      default: total_hdr[31:24] = lump.lump_byte;
    endcase
  end

  always_comb begin
    if (version_hdr != HDR_VERSION) begin
      hdr_err = ST_BAD_VERSION;
    end else if (rate_hdr < MIN_RATE) begin
      hdr_err = ST_RATE_LOW;
    end else if ({1'b0, total_hdr} > COUNT_LIMIT) begin
      hdr_err = ST_TOO_MANY;
    end else begin
      hdr_err = ST_OK;
    end
    if (rate_hdr == OUT_RATE) begin
      hdr_mode = MODE_1X;
    end else if (rate_hdr == HALF_RATE) begin
      hdr_mode = MODE_2X;
    end else if (rate_hdr == QUARTER_RATE) begin
      hdr_mode = MODE_4X;
    end else begin
      hdr_mode = MODE_STEP;
    end
  end

  assign body_sample = (err_code == ST_OK) && (32'(samples_taken) < sample_total);
  assign taken_after = body_sample ? samples_taken + COUNT_BITS'(1) : samples_taken;

  // Step quotient (rate << 16) / 44100 by reciprocal multiplication. The rate
  // word is complete once the fourth header byte has been taken.
  assign inc_prod = (INC_SHIFT+INC_BITS)'(rate_word) * (INC_SHIFT+INC_BITS)'(INC_RECIP);
  assign inc_quo  = inc_prod[INC_SHIFT +: INC_BITS];

  always_comb begin
    state_next = state;
    case (state)
      FR_HEADER: begin
        if (accept && !lump.lump_end && hdr_idx == HDR_LAST) begin
          state_next = FR_BODY;
        end
      end
      FR_BODY: begin
        if (accept && lump.lump_end) begin
          state_next = FR_HEADER;
        end
      end
      default: state_next = FR_HEADER;
    endcase
  end

  always_comb begin
    push     = 1'b0;
    push_cmd = '0;
    case (state)
      FR_HEADER: begin
        if (accept && lump.lump_end) begin
          push                = 1'b1;
          push_cmd.has_status = 1'b1;
          if (hdr_idx != HDR_LAST) begin
            push_cmd.code = ST_SHORT;
          end else if (hdr_err != ST_OK) begin
            push_cmd.code = hdr_err;
          end else if (total_hdr != 32'd0) begin
            push_cmd.code = ST_SHORT;
          end else begin
            push_cmd.code = ST_OK;
          end
        end
      end
      FR_BODY: begin
        if (accept) begin
          push                  = body_sample || lump.lump_end;
          push_cmd.has_sample   = body_sample;
          push_cmd.sample_value = {lump.lump_byte ^ SIGN_FLIP, 8'h00};
          push_cmd.mode         = rate_mode;
          push_cmd.step_inc     = step_inc;
          push_cmd.has_status   = lump.lump_end;
          if (err_code != ST_OK) begin
            push_cmd.code = err_code;
          end else if (32'(taken_after) < sample_total) begin
            push_cmd.code = ST_SHORT;
          end else begin
            push_cmd.code = ST_OK;
          end
        end
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= FR_HEADER;
      hdr_idx       <= '0;
      version_word  <= '0;
      rate_word     <= '0;
      sample_total  <= '0;
      samples_taken <= '0;
      rate_mode     <= MODE_1X;
      step_inc      <= '0;
      err_code      <= ST_OK;
    end else begin
      state <= state_next;
      case (state)
        FR_HEADER: begin
          if (accept) begin
            if (lump.lump_end) begin
              hdr_idx      <= '0;
              version_word <= '0;
              rate_word    <= '0;
              sample_total <= '0;
              rate_mode    <= MODE_1X;
              err_code     <= ST_OK;
            end else begin
              hdr_idx      <= hdr_idx + 3'd1;
              version_word <= version_hdr;
              rate_word    <= rate_hdr;
              sample_total <= total_hdr;
              if (hdr_idx == HDR_LAST) begin
                rate_mode <= hdr_mode;
                err_code  <= hdr_err;
                step_inc  <= (hdr_mode == MODE_STEP) ? inc_quo + INC_BITS'(1) : '0;
              end
            end
          end
        end
        FR_BODY: begin
          if (accept) begin
            if (lump.lump_end) begin
              hdr_idx       <= '0;
              version_word  <= '0;
              rate_word     <= '0;
              sample_total  <= '0;
              samples_taken <= '0;
              rate_mode     <= MODE_1X;
              step_inc      <= '0;
              err_code      <= ST_OK;
            end else begin
              samples_taken <= taken_after;
            end
          end
        end
        default: hdr_idx <= hdr_idx;
      endcase
    end
  end

endmodule

### sv/sltp_fifo.sv
`timescale 1ns / 1ps
// Small command queue between the front end and the frame generator.
module sltp_fifo
  import sltp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_status
);

  cmd_t                    entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_BITS:0]   count;

  assign head           = entries[rd_ptr];
  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_PTR_BITS + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_PTR_BITS + 1)'(1);
      end
    end
  end

endmodule

### sv/sltp_back.sv
`timescale 1ns / 1ps
// Back end: expands queued samples into 44100 Hz frames and sends status items.
module sltp_back
  import sltp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      head,
  input  q_status_t q_status,
  output logic      pop,
  output logic      pcm_valid,
  input  logic      pcm_stall,
  output out_item_t pcm
);

  back_state_t          state, state_next;
  cmd_t                 cur;
  logic [5:0]           rep_n;
  logic [STEP_BITS-1:0] accum;

  logic                 out_free, stepped, skip, last_frame, frames_done, emit;
  logic [STEP_BITS-1:0] acc_add;
  out_item_t            emit_item;
  back_state_t          load_state;

  function automatic logic [5:0] last_rep(rate_mode_t m);
    case (m)
      MODE_2X: return 6'd1;
      MODE_4X: return 6'd3;
      default: return 6'd0;
    endcase
  endfunction

  assign out_free   = !pcm_valid || !pcm_stall;
  assign stepped    = (cur.mode == MODE_STEP);
  assign skip       = stepped && (accum >= ONE_STEP);
  assign acc_add    = accum + STEP_BITS'(cur.step_inc);
  assign last_frame = stepped ? ((acc_add >= ONE_STEP) || (rep_n == REPEAT_CAP - 6'd1))
                              : (rep_n == last_rep(cur.mode));
  assign load_state = head.has_sample ? BK_FRAMES : BK_STATUS;

  always_comb begin
    pop         = 1'b0;
    emit        = 1'b0;
    frames_done = 1'b0;
    emit_item   = '0;
    case (state)
      BK_EMPTY: begin
        pop = !q_status.empty;
      end
      BK_FRAMES: begin
        if (skip) begin
          frames_done = 1'b1;
        end else if (out_free) begin
          emit                   = 1'b1;
          emit_item.left_sample  = signed'(cur.sample_value);
          emit_item.right_sample = signed'(cur.sample_value);
          frames_done            = last_frame;
        end
        pop = frames_done && !cur.has_status && !q_status.empty;
      end
      BK_STATUS: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.is_status   = 1'b1;
          emit_item.status_code = cur.code;
          emit_item.last_item   = 1'b1;
          pop                   = !q_status.empty;
        end
      end
      default: pop = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_EMPTY: begin
        if (pop) begin
          state_next = load_state;
        end
      end
      BK_FRAMES: begin
        if (frames_done) begin
          if (cur.has_status) begin
            state_next = BK_STATUS;
          end else begin
            state_next = pop ? load_state : BK_EMPTY;
          end
        end
      end
      BK_STATUS: begin
        if (emit) begin
          state_next = pop ? load_state : BK_EMPTY;
        end
      end
      default: state_next = BK_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      pcm <= emit_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_EMPTY;
      rep_n     <= '0;
      accum     <= '0;
      pcm_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        pcm_valid <= 1'b1;
      end else if (!pcm_stall) begin
        pcm_valid <= 1'b0;
      end
      case (state)
        BK_FRAMES: begin
          if (skip) begin
            accum <= accum - ONE_STEP;
          end else if (emit) begin
            rep_n <= last_frame ? 6'd0 : rep_n + 6'd1;
            if (stepped) begin
              accum <= last_frame ? acc_add - ONE_STEP : acc_add;
            end
          end
        end
        BK_STATUS: begin
          if (emit) begin
            accum <= '0;
            rep_n <= '0;
          end
        end
        default: rep_n <= rep_n;
      endcase
    end
  end

endmodule

### sv/sound_lump_to_pcm16_resampler_top.sv
`timescale 1ns / 1ps
// Top level of the sound lump to PCM16 zero-order-hold resampler.
// The block takes a sound lump one byte per request: an eight-byte little-endian
// header (version, which must be 3, then rate, then a 32-bit sample count) and then
// unsigned 8-bit samples. Each sample leaves as a signed 16-bit stereo frame at
// 44100 Hz, repeated once, twice or four times for 44100, 22050 and 11025 Hz, and
// by a 2.16 step accumulator for any other rate. The byte marked lump_end closes
// the lump with one status request whose last_item is set. A front end takes one
// byte per cycle whenever the command queue has room; the step increment for a
// rate other than the three standard ones comes from a reciprocal multiplication
// as the last header byte is taken, so the header never stalls the byte stream. A
// four-entry command queue decouples it from the frame generator, which sends one
// frame per cycle while the output is not stalled. A skipped sample and a status
// request each take a step of their own, and a command that reaches an idle
// generator is loaded before its first frame goes out.

module sound_lump_to_pcm16_resampler_top
  import sltp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // Incoming lump bytes.
  input  logic      lump_valid,
  output logic      lump_stall,
  input  in_item_t  lump,
  // Outgoing frames and status.
  output logic      pcm_valid,
  input  logic      pcm_stall,
  output out_item_t pcm
);

  // Commands flow from the parser through the queue into the frame generator.
  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_status;

  // Header parsing, sample counting and rate classification.
  sltp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .lump_valid (lump_valid),
    .lump_stall (lump_stall),
    .lump       (lump),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_status   (q_status)
  );

  // The queue lets the parser run ahead while frames are still being sent.
  sltp_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_status (q_status)
  );

  // Frame generation and the registered output stage.
  sltp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .pcm_valid (pcm_valid),
    .pcm_stall (pcm_stall),
    .pcm       (pcm)
  );

endmodule

### sv/sltp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the resampler top level, with its bind statement.
`include "sound_lump_to_pcm16_resampler_top_macros.svh"

module sltp_checker
  import sltp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      lump_valid,
  input logic      lump_stall,
  input in_item_t  lump,
  input logic      pcm_valid,
  input logic      pcm_stall,
  input out_item_t pcm
);

  `SLTP_ASSERT_NEXT(a_pcm_hold, pcm_valid && pcm_stall, pcm_valid && $stable(pcm), "stalled output request changed")
  `SLTP_ASSERT_IMPL(a_frame_shape, pcm_valid && !pcm.is_status, pcm.left_sample == pcm.right_sample && pcm.status_code == ST_OK && !pcm.last_item && pcm.left_sample[7:0] == 8'h00, "malformed frame")
  `SLTP_ASSERT_IMPL(a_status_shape, pcm_valid && pcm.is_status, pcm.last_item && pcm.left_sample == 16'sd0 && pcm.right_sample == 16'sd0 && pcm.status_code <= ST_SHORT, "malformed status")
  `SLTP_ASSERT_AFTER_RESET(a_reset_idle, !pcm_valid && !lump_stall, "not idle after reset")

endmodule

bind sound_lump_to_pcm16_resampler_top sltp_checker u_sltp_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sound lump to PCM16 resampler with its own predictor.
module testbench;
  import sltp_pkg::*;

  // Cycles to wait once nothing is expected. This covers the four-entry
  // command queue and the frame generator with room to spare.
  localparam int SETTLE_CYCLES = 64;
  // Upper bound on cycles spent waiting for outstanding results at the end.
  localparam int DRAIN_LIMIT   = 50000;

  logic      clk = 1'b0;
  logic      rst;
  logic      lump_valid;
  logic      lump_stall;
  in_item_t  lump;
  logic      pcm_valid;
  logic      pcm_stall;
  out_item_t pcm;

  sound_lump_to_pcm16_resampler_top u_top (
    .clk        (clk),
    .rst        (rst),
    .lump_valid (lump_valid),
    .lump_stall (lump_stall),
    .lump       (lump),
    .pcm_valid  (pcm_valid),
    .pcm_stall  (pcm_stall),
    .pcm        (pcm)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the block's lump parser: header bytes seen,
  // the three header words, the sample count so far, the 2.16 step
  // accumulator with its increment, the repeat mode and the sticky header error.
  // ---------------------------------------------------------------------------
  logic [3:0]          hdr_count;
  logic [15:0]         lump_version;
  logic [15:0]         lump_rate;
  logic [31:0]         lump_count;
  logic [31:0]         samples_seen;
  logic [STEP_BITS-1:0] accum;
  logic [INC_BITS-1:0] accum_inc;
  rate_mode_t          lump_mode;
  logic                held_error;

  // Frames and status requests still owed by the block, oldest first.
  out_item_t pending_pcm[$];

  int errors;
  int bytes_sent;
  int useful_bytes;
  int frames_checked;
  int status_checked;

  // Sender and receiver idling knobs, changed from one test to the next.
  int gap_max;
  int burst_left;
  int stall_pct;
  int stall_left;

  function automatic void clear_lump_state();
    hdr_count    = '0;
    lump_version = '0;
    lump_rate    = '0;
    lump_count   = '0;
    samples_seen = '0;
    accum        = '0;
    accum_inc    = '0;
    lump_mode    = MODE_1X;
    held_error   = 1'b0;
  endfunction

  // Header faults are reported in a fixed order: version, then rate, then count.
  function automatic logic [2:0] header_fault();
    if (lump_version != HDR_VERSION) return ST_BAD_VERSION;
    if (lump_rate < MIN_RATE) return ST_RATE_LOW;
    if ({1'b0, lump_count} > COUNT_LIMIT) return ST_TOO_MANY;
    return ST_OK;
  endfunction

  function automatic void expect_pcm(input logic [15:0] value, input logic st,
                                     input logic [2:0] code, input logic last);
    out_item_t r;
    r.left_sample  = value;
    r.right_sample = value;
    r.is_status    = st;
    r.status_code  = code;
    r.last_item    = last;
    pending_pcm.push_back(r);
  endfunction

  // Works out the requests that one accepted lump byte causes and queues them.
  // Returns 0 when the byte has no effect at all, which is the case for
  // surplus bytes and for samples after a bad header.
  function automatic bit resample_byte(input in_item_t item);
    logic [15:0] value;
    logic [31:0] wide;
    logic [2:0]  code;
    int          idx;
    int          reps;
    bit          used;
    used = 1'b1;
    if (hdr_count < 4'd8) begin
      idx = hdr_count;
      if (idx < 2) lump_version[idx*8 +: 8] = item.lump_byte;
      else if (idx < 4) lump_rate[(idx-2)*8 +: 8] = item.lump_byte;
      else lump_count[(idx-4)*8 +: 8] = item.lump_byte;
      hdr_count++;
      if (hdr_count == 4'd8) begin
        held_error = header_fault() != ST_OK;
        accum      = '0;
        accum_inc  = '0;
        if (lump_rate == OUT_RATE) lump_mode = MODE_1X;
        else if (lump_rate == HALF_RATE) lump_mode = MODE_2X;
        else if (lump_rate == QUARTER_RATE) lump_mode = MODE_4X;
        else begin
          lump_mode = MODE_STEP;
          wide      = {lump_rate, 16'h0000} / {16'h0000, OUT_RATE} + 32'd1;
          accum_inc = wide[INC_BITS-1:0];
        end
      end
    end else if (!held_error && samples_seen < lump_count) begin
      value = {item.lump_byte ^ SIGN_FLIP, 8'h00};
      samples_seen++;
      if (lump_mode == MODE_STEP) begin
        // A sample that lands while the accumulator is at 1.0 or more is
        // skipped; otherwise it repeats until the accumulator reaches 1.0 or REPEAT_CAP frames are out.
        reps = 0;
        while (accum < ONE_STEP && reps < REPEAT_CAP) begin
          expect_pcm(value, 1'b0, ST_OK, 1'b0);
          accum = accum + accum_inc;
          reps++;
        end
        accum = accum - ONE_STEP;
      end else begin
        reps = (lump_mode == MODE_1X) ? 1 : ((lump_mode == MODE_2X) ? 2 : 4);
        repeat (reps) expect_pcm(value, 1'b0, ST_OK, 1'b0);
      end
    end else begin
      used = 1'b0;
    end
    if (item.lump_end) begin
      if (hdr_count < 4'd8) code = ST_SHORT;
      else if (held_error) code = header_fault();
      else if (samples_seen < lump_count) code = ST_SHORT;
      else code = ST_OK;
      expect_pcm(16'h0000, 1'b1, code, 1'b1);
      clear_lump_state();
      used = 1'b1;
    end
    return used;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge; a request is taken at the rising
  // edge where valid is high and stall is low. Bytes go out in bursts of
  // random length, with idle gaps between bursts when gap_max is nonzero.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic e);
    in_item_t item;
    int       gap;
    item.lump_byte = b;
    item.lump_end  = e;
    @(negedge clk);
    lump       <= item;
    lump_valid <= 1'b1;
    do @(posedge clk); while (lump_stall);
    if (resample_byte(item)) useful_bytes++;
    bytes_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = $urandom_range(1, gap_max);
        @(negedge clk);
        lump_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Sends the first hdr_len bytes of a header; close marks the last one as
  // the end of the lump.
  task automatic send_header(input logic [15:0] ver, input logic [15:0] rate,
                             input logic [31:0] count, input int hdr_len,
                             input bit close);
    logic [63:0] hdr;
    hdr = {count, rate, ver};
    for (int i = 0; i < hdr_len; i++)
      send_byte(hdr[i*8 +: 8], close && (i == hdr_len - 1));
  endtask

  // Samples lean on the code extremes now and then.
  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SIGN_FLIP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // A full header followed by n_samples random samples, the last byte ending
  // the lump. n_samples may be below or above count on purpose.
  task automatic send_lump(input logic [15:0] ver, input logic [15:0] rate,
                           input logic [31:0] count, input int n_samples);
    send_header(ver, rate, count, 8, n_samples == 0);
    for (int i = 0; i < n_samples; i++)
      send_byte(pick_sample(), i == n_samples - 1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver. It stalls in runs, starting a run with probability stall_pct
  // on each cycle it is not already stalled.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pcm_stall <= 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      pcm_stall <= 1'b1;
      stall_left = $urandom_range(0, 5);
    end else begin
      pcm_stall <= 1'b0;
    end
  end

  // Every accepted request is checked against the oldest expectation.
  always @(posedge clk) begin : check_pcm
    out_item_t want;
    if (!rst && pcm_valid && !pcm_stall) begin
      if (pending_pcm.size() == 0) begin
        $display("%0t: unexpected request L=%0d R=%0d st=%0b code=%0d last=%0b", $time,
                 pcm.left_sample, pcm.right_sample, pcm.is_status, pcm.status_code,
                 pcm.last_item);
        errors++;
      end else begin
        want = pending_pcm.pop_front();
        if (pcm.left_sample !== want.left_sample || pcm.right_sample !== want.right_sample ||
            pcm.is_status !== want.is_status || pcm.status_code !== want.status_code ||
            pcm.last_item !== want.last_item) begin
          $display("%0t: mismatch, expected L=%0d R=%0d st=%0b code=%0d last=%0b", $time,
                   want.left_sample, want.right_sample, want.is_status, want.status_code,
                   want.last_item);
          $display("%0t:           actual   L=%0d R=%0d st=%0b code=%0d last=%0b", $time,
                   pcm.left_sample, pcm.right_sample, pcm.is_status, pcm.status_code,
                   pcm.last_item);
          errors++;
        end
        if (want.is_status) status_checked++;
        else frames_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Lowest and highest sample codes at the 4x rate, a single-repeat lump with a
  // surplus byte, and a lump cut off inside its header.
  task automatic test_directed_edges();
    send_header(HDR_VERSION, QUARTER_RATE, 32'd2, 8, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_header(HDR_VERSION, OUT_RATE, 32'd1, 8, 1'b0);
    send_byte(SIGN_FLIP, 1'b0);
    send_byte(8'h7F, 1'b1);
    send_header(HDR_VERSION, HALF_RATE, 32'd4, 3, 1'b1);
  endtask

  // The three repeat rates. The first lumps run with no idling on either side.
  task automatic test_standard_rates(input int target);
    int          stop_at;
    logic [15:0] rate;
    int          count;
    int          n;
    stop_at = useful_bytes + target;
    while (useful_bytes < stop_at) begin
      if (useful_bytes > stop_at - target + 25) begin
        gap_max   = 8;
        stall_pct = 30;
      end
      case ($urandom_range(0, 2))
        0: rate = OUT_RATE;
        1: rate = HALF_RATE;
        default: rate = QUARTER_RATE;
      endcase
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      n     = count;
      if ($urandom_range(0, 5) == 0) n = count + $urandom_range(1, 3);
      send_lump(HDR_VERSION, rate, count, n);
    end
  endtask

  // Rates off the standard grid, including the lowest accepted rate with its
  // long repeats and rates above 44100 Hz where samples are skipped.
  task automatic test_stepped_rates(input int target);
    int          stop_at;
    logic [15:0] rate;
    int          count;
    stop_at = useful_bytes + target;
    while (useful_bytes < stop_at) begin
      case ($urandom_range(0, 5))
        0: rate = MIN_RATE;
        1: rate = 16'hFFFF;
        2: rate = OUT_RATE - 16'd1;
        3: rate = OUT_RATE + 16'd1;
        4: rate = 16'($urandom_range(700, 2000));
        default: rate = 16'($urandom_range(2001, 65535));
      endcase
      count = (rate < 16'd2000) ? $urandom_range(1, 3) : $urandom_range(0, 16);
      send_lump(HDR_VERSION, rate, count, count);
    end
  endtask

  // Bad version, rate below the floor and counts beyond the counter, alone and
  // in combination. Samples after such a header must give no frames.
  task automatic test_header_errors(input int target);
    int          stop_at;
    logic [15:0] ver;
    logic [15:0] rate;
    logic [31:0] count;
    stop_at = useful_bytes + target;
    while (useful_bytes < stop_at) begin
      ver   = HDR_VERSION;
      rate  = OUT_RATE;
      count = $urandom_range(0, 4);
      case ($urandom_range(0, 4))
        0: ver = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom_range(4, 65535));
        1: rate = ($urandom_range(0, 1) == 0) ? MIN_RATE - 16'd1 : 16'($urandom_range(0, 699));
        2: count = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF :
                   {8'($urandom_range(1, 255)), 24'($urandom)};
        3: begin
          ver   = 16'h0000;
          rate  = 16'h0000;
          count = 32'h0100_0000;
        end
        default: begin
          rate  = 16'($urandom_range(0, 699));
          count = {8'($urandom_range(1, 255)), 24'($urandom)};
        end
      endcase
      send_lump(ver, rate, count, $urandom_range(0, 4));
    end
    // Largest count the counter takes, sent short so the lump stays small.
    send_lump(HDR_VERSION, OUT_RATE, 32'h00FF_FFFF, 2);
  endtask

  // Lumps that end early, carry extra bytes or declare no samples at all.
  task automatic test_ragged_lumps(input int target);
    int          stop_at;
    logic [15:0] rate;
    int          count;
    stop_at = useful_bytes + target;
    while (useful_bytes < stop_at) begin
      rate = ($urandom_range(0, 1) == 0) ? QUARTER_RATE : 16'($urandom_range(700, 65535));
      case ($urandom_range(0, 3))
        0: send_header(HDR_VERSION, rate, $urandom_range(0, 8), $urandom_range(1, 7), 1'b1);
        1: begin
          count = $urandom_range(2, 10);
          send_lump(HDR_VERSION, rate, count, $urandom_range(1, count - 1));
        end
        2: begin
          count = $urandom_range(0, 6);
          send_lump(HDR_VERSION, rate, count, count + $urandom_range(1, 4));
        end
        default: send_lump(HDR_VERSION, rate, 32'd0, $urandom_range(0, 2));
      endcase
    end
  endtask

  // Random bytes with random lump ends, closed by one final end byte.
  task automatic test_byte_noise(input int target);
    int stop_at;
    stop_at = useful_bytes + target;
    while (useful_bytes < stop_at)
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int waited;
    rst            = 1'b1;
    lump_valid     = 1'b0;
    lump           = '0;
    pcm_stall      = 1'b0;
    errors         = 0;
    bytes_sent     = 0;
    useful_bytes   = 0;
    frames_checked = 0;
    status_checked = 0;
    gap_max        = 0;
    burst_left     = 0;
    stall_pct      = 0;
    stall_left     = 0;
    clear_lump_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_edges();
    test_standard_rates(55);
    gap_max   = 3;
    stall_pct = 50;
    test_stepped_rates(60);
    gap_max   = 8;
    stall_pct = 20;
    test_header_errors(30);
    gap_max   = 0;
    stall_pct = 60;
    test_ragged_lumps(35);
    gap_max   = 5;
    stall_pct = 10;
    test_byte_noise(35);

    @(negedge clk);
    lump_valid <= 1'b0;
    stall_pct = 0;
    waited    = 0;
    while (pending_pcm.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_pcm.size() != 0) begin
      $display("%0t: %0d expected requests never arrived", $time, pending_pcm.size());
      errors++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("summary: %0d lump bytes sent over standard, stepped, faulty, ragged and noisy lumps",
             bytes_sent);
    $display("summary: %0d frames and %0d status requests checked, %0d mismatches",
             frames_checked, status_checked, errors);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #16_000_000;
    $display("%0t: timeout with %0d requests outstanding", $time, pending_pcm.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule
